// File: hw/rtl/crc_pkg.sv
package crc_pkg;

    // canvas geometry
    localparam int CRC_MAX_WIDTH  = 256;
    localparam int CRC_MAX_HEIGHT = 256;
    localparam int CRC_COL_W      = $clog2(CRC_MAX_WIDTH);
    localparam int CRC_ROW_W      = $clog2(CRC_MAX_HEIGHT);
    localparam int CRC_ADDR_W     = CRC_COL_W + CRC_ROW_W;
    localparam int CRC_DEPTH      = 1 << CRC_ADDR_W;
    localparam int CRC_DIM_W      = 9;

    // arithmetic widths
    localparam int CRC_Q_W     = 20;
    localparam int CRC_SQ_W    = 2 * CRC_Q_W;
    localparam int CRC_DELTA_W = 22;
    localparam int CRC_DIST_W  = 42;
    localparam int CRC_CNT_W   = $clog2(CRC_Q_W + 1);

    // commands
    localparam logic [1:0] CMD_CLEAR = 2'd0;
    localparam logic [1:0] CMD_DRAW  = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // shape codes
    localparam logic [7:0] SHAPE_FILLED = 8'h43;
    localparam logic [7:0] SHAPE_RING   = 8'h63;

    // register indexes
    localparam logic [1:0] CFG_WIDTH      = 2'd0;
    localparam logic [1:0] CFG_HEIGHT     = 2'd1;
    localparam logic [1:0] CFG_BACKGROUND = 2'd2;

    // magnitude of a signed Q.8 value, full negative range included
    function automatic logic [CRC_Q_W-1:0] crc_abs(input logic [CRC_Q_W-1:0] v);
        crc_abs = v[CRC_Q_W-1] ? (CRC_Q_W'(0) - v) : v;
    endfunction

    // saturate a size register into 1..max
    function automatic logic [CRC_DIM_W-1:0] crc_sat(input logic [CRC_DIM_W-1:0] v,
                                                    input logic [CRC_DIM_W-1:0] max);
        if (v == '0) begin
            crc_sat = CRC_DIM_W'(1);
        end else if (v > max) begin
            crc_sat = max;
        end else begin
            crc_sat = v;
        end
    endfunction

endpackage

// File: hw/rtl/crc_ram.sv
module crc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/crc_square.sv
module crc_square import crc_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [CRC_Q_W-1:0]  i_operand,
    output logic                o_busy,
    output logic                o_done,
    output logic [CRC_SQ_W-1:0] o_square
);

    logic [CRC_CNT_W-1:0] r_cnt;
    logic                 r_done;
    logic [CRC_SQ_W-1:0]  r_acc;
    logic [CRC_SQ_W-1:0]  r_mcand;
    logic [CRC_Q_W-1:0]   r_mplier;

    // control: one multiplier bit per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= (r_cnt == CRC_CNT_W'(1));
            if (i_start) begin
                r_cnt <= CRC_CNT_W'(CRC_Q_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - CRC_CNT_W'(1);
            end
        end
    end

    // shift-add datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc    <= '0;
            r_mcand  <= {{(CRC_SQ_W-CRC_Q_W){1'b0}}, i_operand};
            r_mplier <= i_operand;
        end else if (r_cnt != '0) begin
            if (r_mplier[0]) begin
                r_acc <= r_acc + r_mcand;
            end
            r_mcand  <= {r_mcand[CRC_SQ_W-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[CRC_Q_W-1:1]};
        end
    end

    assign o_busy   = (r_cnt != '0);
    assign o_done   = r_done;
    assign o_square = r_acc;

endmodule

// File: hw/rtl/circle_raster_canvas_unit.sv
// channel   dir  handshake                      words
// s_axis    in   s_axis_tvalid/s_axis_tready    one command word
// m_axis    out  m_axis_tvalid/m_axis_tready    one result word per command
// cfg       in   i_cfg_valid/o_cfg_ready        register index and value
//
// clear writes one pixel per cycle through the canvas ram write port
// draw runs four squares on the shift-add squarer, then sweeps one pixel per cycle,
// with a row setup state (S_ROW) before each row
// read passes through S_READ and S_RDATA (registered ram read); error and unused commands go straight to S_OUT
// the canvas holds no reset value; read only after a clear
// s_axis_tready is high only when idle; a finished result waits in its state until
// the output register is free, and the output register frees on m_axis_tready
module circle_raster_canvas_unit import crc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // shape_type[7:0], center_x[27:8], center_y[47:28], radius[67:48],
    // color[75:68], pixel_col[83:76], pixel_row[91:84], zero pad[95:92]
    input  logic [95:0] s_axis_tdata,
    // command[1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pixel_value[7:0]
    output logic [7:0]  m_axis_tdata,
    // shape_error[0]
    output logic [0:0]  m_axis_tuser,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CLEAR  = 8'b0000_0010,
        S_SQUARE = 8'b0000_0100,
        S_ROW    = 8'b0000_1000,
        S_PIXEL  = 8'b0001_0000,
        S_READ   = 8'b0010_0000,
        S_RDATA  = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } t_state;

    t_state r_state;

    // configuration
    logic [CRC_DIM_W-1:0] r_cfg_width;
    logic [CRC_DIM_W-1:0] r_cfg_height;
    logic [7:0]           r_background;
    logic [CRC_DIM_W-1:0] w_used;
    logic [CRC_DIM_W-1:0] h_used;

    // command fields
    logic [7:0]         in_type;
    logic [CRC_Q_W-1:0] in_cx;
    logic [CRC_Q_W-1:0] in_cy;
    logic [CRC_Q_W-1:0] in_rad;
    logic [7:0]         in_color;
    logic [7:0]         in_pc;
    logic [7:0]         in_pr;
    logic               in_accept;
    logic               draw_bad;

    // draw working registers
    logic [CRC_Q_W-1:0]     r_cx;
    logic [CRC_Q_W-1:0]     r_cy;
    logic [CRC_Q_W-1:0]     r_rad;
    logic [7:0]             r_color;
    logic                   r_filled;
    logic                   r_has_inner;
    logic [1:0]             r_sq_sel;
    logic [CRC_SQ_W-1:0]    r_cx2;
    logic [CRC_SQ_W-1:0]    r_outer;
    logic [CRC_SQ_W-1:0]    r_inner;
    logic [CRC_DIST_W-1:0]  r_dy2;
    logic [CRC_DIST_W-1:0]  r_dsq;
    logic [CRC_DELTA_W-1:0] r_dx;
    logic [CRC_DELTA_W-1:0] r_dy;
    logic [CRC_COL_W-1:0]   r_col;
    logic [CRC_ROW_W-1:0]   r_row;
    logic                   r_rd_ok;

    // result staging and output register
    logic [7:0] r_res_data;
    logic       r_res_err;
    logic       r_m_valid;
    logic [7:0] r_m_data;
    logic       r_m_err;

    // squarer interface
    logic                sq_start;
    logic [CRC_Q_W-1:0]  sq_operand;
    logic                sq_busy;
    logic                sq_done;
    logic [CRC_SQ_W-1:0] sq_square;
    logic [1:0]          n_sq_sel;

    // sweep helpers
    logic                  last_col;
    logic                  last_row;
    logic                  paint;
    logic [CRC_DIST_W-1:0] n_dsq;
    logic [CRC_DIST_W-1:0] n_dy2;
    logic                  ram_we;
    logic [7:0]            ram_wdata;
    logic [7:0]            ram_rdata;
    logic [CRC_ADDR_W-1:0] ram_addr;

    // field unpacking
    assign in_type  = s_axis_tdata[7:0];
    assign in_cx    = s_axis_tdata[27:8];
    assign in_cy    = s_axis_tdata[47:28];
    assign in_rad   = s_axis_tdata[67:48];
    assign in_color = s_axis_tdata[75:68];
    assign in_pc    = s_axis_tdata[83:76];
    assign in_pr    = s_axis_tdata[91:84];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign w_used = crc_sat(r_cfg_width, CRC_DIM_W'(CRC_MAX_WIDTH));
    assign h_used = crc_sat(r_cfg_height, CRC_DIM_W'(CRC_MAX_HEIGHT));

    // bad radius or unknown shape
    assign draw_bad = in_rad[CRC_Q_W-1] || (in_rad == '0) ||
                      ((in_type != SHAPE_FILLED) && (in_type != SHAPE_RING));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_width  <= CRC_DIM_W'(256);
            r_cfg_height <= CRC_DIM_W'(256);
            r_background <= 8'd32;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WIDTH:      r_cfg_width  <= i_cfg_data;
                CFG_HEIGHT:     r_cfg_height <= i_cfg_data;
                CFG_BACKGROUND: r_background <= i_cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // squarer operand sequence: |cx|, |cy|, r, r-1.0 (zero when the radius is below 1.0)
    assign n_sq_sel = r_sq_sel + 2'd1;
    always_comb begin
        sq_start   = 1'b0;
        sq_operand = crc_abs(in_cx);
        if (r_state == S_IDLE) begin
            sq_start = in_accept && (s_axis_tuser == CMD_DRAW) && !draw_bad;
        end else if (r_state == S_SQUARE) begin
            sq_start = sq_done && (r_sq_sel != 2'd3);
            case (n_sq_sel)
                2'd1:    sq_operand = crc_abs(r_cy);
                2'd2:    sq_operand = r_rad;
                2'd3:    sq_operand = r_has_inner ? (r_rad - CRC_Q_W'(256)) : '0;
                default: sq_operand = crc_abs(r_cx);
            endcase
        end
    end

    crc_square u_square (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (sq_start),
        .i_operand (sq_operand),
        .o_busy    (sq_busy),
        .o_done    (sq_done),
        .o_square  (sq_square)
    );

    // incremental squared distance: (d+256)^2 = d^2 + 512*d + 65536
    assign n_dsq = r_dsq + {{11{r_dx[CRC_DELTA_W-1]}}, r_dx, 9'b0} + CRC_DIST_W'(65536);
    assign n_dy2 = r_dy2 + {{11{r_dy[CRC_DELTA_W-1]}}, r_dy, 9'b0} + CRC_DIST_W'(65536);

    assign last_col = ({1'b0, r_col} == (w_used - CRC_DIM_W'(1)));
    assign last_row = ({1'b0, r_row} == (h_used - CRC_DIM_W'(1)));

    // coverage test
    assign paint = (r_dsq <= {2'b0, r_outer}) &&
                   (r_filled || !(r_has_inner && (r_dsq <= {2'b0, r_inner})));

    // canvas ram hookup
    assign ram_addr  = {r_row, r_col};
    assign ram_we    = (r_state == S_CLEAR) || ((r_state == S_PIXEL) && paint);
    assign ram_wdata = (r_state == S_CLEAR) ? r_background : r_color;

    crc_ram #(
        .WIDTH (8),
        .DEPTH (CRC_DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_addr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_addr),
        .o_rdata (ram_rdata)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        case (s_axis_tuser)
                            CMD_CLEAR: r_state <= S_CLEAR;
                            CMD_DRAW:  r_state <= draw_bad ? S_OUT : S_SQUARE;
                            CMD_READ:  r_state <= S_READ;
                            default:   r_state <= S_OUT;
                        endcase
                    end
                end
                S_CLEAR: begin
                    if (last_col && last_row) begin
                        r_state <= S_OUT;
                    end
                end
                S_SQUARE: begin
                    if (sq_done && (r_sq_sel == 2'd3)) begin
                        r_state <= S_ROW;
                    end
                end
                S_ROW:   r_state <= S_PIXEL;
                S_PIXEL: begin
                    if (last_col) begin
                        r_state <= last_row ? S_OUT : S_ROW;
                    end
                end
                S_READ:  r_state <= S_RDATA;
                S_RDATA: r_state <= S_OUT;
                S_OUT: begin
                    if (!r_m_valid || m_axis_tready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_res_data  <= '0;
                r_res_err   <= 1'b0;
                r_col       <= in_pc;
                r_row       <= in_pr;
                r_rd_ok     <= ({1'b0, in_pc} < w_used) && ({1'b0, in_pr} < h_used);
                r_cx        <= in_cx;
                r_cy        <= in_cy;
                r_rad       <= in_rad;
                r_color     <= in_color;
                r_filled    <= (in_type == SHAPE_FILLED);
                r_has_inner <= (in_rad[CRC_Q_W-2:8] != '0);
                r_sq_sel    <= '0;
                if (in_accept && (s_axis_tuser == CMD_DRAW) && draw_bad) begin
                    r_res_err <= 1'b1;
                end
                if (in_accept && (s_axis_tuser == CMD_CLEAR)) begin
                    r_col <= '0;
                    r_row <= '0;
                end
            end
            S_CLEAR: begin
                r_col <= last_col ? '0 : (r_col + CRC_COL_W'(1));
                if (last_col) begin
                    r_row <= r_row + CRC_ROW_W'(1);
                end
            end
            S_SQUARE: begin
                if (sq_done) begin
                    r_sq_sel <= n_sq_sel;
                    case (r_sq_sel)
                        2'd0:    r_cx2   <= sq_square;
                        2'd1:    r_dy2   <= {2'b0, sq_square};
                        2'd2:    r_outer <= sq_square;
                        default: r_inner <= sq_square;
                    endcase
                end
                r_row <= '0;
                r_dy  <= CRC_DELTA_W'(0) - {{2{r_cy[CRC_Q_W-1]}}, r_cy};
            end
            S_ROW: begin
                r_dsq <= {2'b0, r_cx2} + r_dy2;
                r_dx  <= CRC_DELTA_W'(0) - {{2{r_cx[CRC_Q_W-1]}}, r_cx};
                r_col <= '0;
            end
            S_PIXEL: begin
                r_dsq <= n_dsq;
                r_dx  <= r_dx + CRC_DELTA_W'(256);
                r_col <= r_col + CRC_COL_W'(1);
                if (last_col) begin
                    r_row <= r_row + CRC_ROW_W'(1);
                    r_dy2 <= n_dy2;
                    r_dy  <= r_dy + CRC_DELTA_W'(256);
                end
            end
            S_RDATA: begin
                r_res_data <= r_rd_ok ? ram_rdata : 8'd0;
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_m_valid || m_axis_tready)) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_m_valid || m_axis_tready)) begin
            r_m_data <= r_res_data;
            r_m_err  <= r_res_err;
        end
    end

    assign m_axis_tvalid   = r_m_valid;
    assign m_axis_tdata    = r_m_data;
    assign m_axis_tuser[0] = r_m_err;

    // canvas is written only by the clear and pixel sweeps
    a_write_in_sweep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ((r_state == S_CLEAR) || (r_state == S_PIXEL)))
        else $error("canvas write outside a sweep");

    // squarer is restarted only once it has finished
    a_square_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_start |-> !sq_busy)
        else $error("squarer started while busy");

    // a new result appears only from the result state
    a_result_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == S_OUT))
        else $error("result word without a finished command");

    // an error result never carries a pixel
    a_error_clean : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_err) |-> (r_m_data == 8'd0))
        else $error("error result with pixel data");

endmodule
